>>> hdl/sorted_priority_queue_unit_defines.svh
// assertion macros shared by the priority queue rtl
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");

`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");

`else

`define SPQ_ASSERT_IMPLY(label, clk, rst, cond, expr)

`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

>>> hdl/spq_pkg.sv
// types, constants and helpers for the sorted priority queue
package spq_pkg;

   localparam int QUEUE_DEPTH = 64;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int PRIO_W      = 16;
   localparam int OCC_W       = 7;

   typedef enum logic {
      MODE_INSERT = 1'b0,
      MODE_REMOVE = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      mode_type                   mode;
      logic signed [DATA_W-1:0]   item_data;
      logic        [PRIO_W-1:0]   item_priority;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   head_data;
      logic        [PRIO_W-1:0]   head_priority;
      status_type                 status;
      logic        [OCC_W-1:0]    occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]   data;
      logic        [PRIO_W-1:0]   prio;
   } entry_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                       ins_en;
      logic                       rem_en;
      entry_type                  new_entry;
   } cell_ctrl_type;

   function automatic logic [OCC_W-1:0] to_occupancy(input logic [CNT_W-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return wide[OCC_W-1:0];
   endfunction

endpackage

>>> hdl/spq_cell.sv
// one slot of the sorted shift chain
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   prev_keep,
   input  spq_pkg::entry_type     prev_entry,
   input  spq_pkg::entry_type     next_entry,
   output spq_pkg::entry_type     entry,
   output logic                   keep
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   // a stored entry stays put when it outranks the new one
   assign keep  = occupied && (entry_ff.prio > ctrl.new_entry.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.ins_en) begin
         if (!keep) begin
            entry_in = prev_keep ? ctrl.new_entry : prev_entry;
         end
      end else if (ctrl.rem_en) begin
         entry_in = next_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> hdl/sorted_priority_queue_unit.sv
// sorted priority queue: a chain of entry cells with the highest priority at the head
//
// Usage:
//   Raise start with req_word for one cycle to issue an insert or a remove; the word is
//   taken at any edge where start is high and busy is low. busy stays low, so a new word
//   may follow in every cycle.
//   Each word gives exactly one response word in the cycle after it is taken: rsp_strobe is
//   high for that single cycle and rsp_word carries the removed head data and priority
//   (zero for other words), status and the occupancy after the operation. Throughput is
//   one word per cycle: on an insert every cell compares against the new priority and
//   unkept cells shift one place toward the tail; a remove shifts all toward the head.
//   An insert into a full queue returns overflow and a remove from an empty queue
//   returns underflow; neither changes the contents. Among equal priorities the newest
//   entry is served first.
//   Reset clears the occupancy count and the response strobe; cell contents are not
//   cleared and are never read before being written.
//   The receiver cannot stall: the response must be captured in its strobe cycle.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  spq_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output spq_pkg::rsp_word_type rsp_word
);

   localparam int DEPTH = spq_pkg::QUEUE_DEPTH;
   localparam int CW    = spq_pkg::CNT_W;

   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic                  rsp_strobe_ff;
   logic                  rsp_strobe_in;
   spq_pkg::rsp_word_type rsp_word_ff;
   spq_pkg::rsp_word_type rsp_word_in;

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   logic                   rem_on_empty;
   logic                   rsp_underflow;
   spq_pkg::cell_ctrl_type ctrl;
   spq_pkg::entry_type     cell_entry [DEPTH];
   logic                   cell_keep  [DEPTH];

   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign is_full  = (count_ff >= CW'(DEPTH));
   assign is_empty = (count_ff == '0);

   assign ctrl.ins_en         = accept && (req_word.mode == spq_pkg::MODE_INSERT) && !is_full;
   assign ctrl.rem_en         = accept && (req_word.mode == spq_pkg::MODE_REMOVE) && !is_empty;
   assign ctrl.new_entry.data = req_word.item_data;
   assign ctrl.new_entry.prio = req_word.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic               occ;
      logic               pkeep;
      spq_pkg::entry_type pentry;
      spq_pkg::entry_type nentry;

      assign occ = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign pkeep  = 1'b1;
         assign pentry = ctrl.new_entry;
      end else begin : g_body
         assign pkeep  = cell_keep[i-1];
         assign pentry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign nentry = cell_entry[i];
      end else begin : g_mid
         assign nentry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occ),
         .prev_keep  (pkeep),
         .prev_entry (pentry),
         .next_entry (nentry),
         .entry      (cell_entry[i]),
         .keep       (cell_keep[i])
      );
   end

   always_comb begin
      count_in                  = count_ff;
      rsp_strobe_in             = accept;
      rsp_word_in.head_data     = '0;
      rsp_word_in.head_priority = '0;
      rsp_word_in.status        = spq_pkg::STATUS_OK;
      priority if (ctrl.ins_en) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.rem_en) begin
         count_in                  = count_ff - CW'(1);
         rsp_word_in.head_data     = cell_entry[0].data;
         rsp_word_in.head_priority = cell_entry[0].prio;
      end else if (accept) begin
         rsp_word_in.status = (req_word.mode == spq_pkg::MODE_INSERT) ?
                              spq_pkg::STATUS_OVERFLOW : spq_pkg::STATUS_UNDERFLOW;
      end else begin
         count_in = count_ff;
      end
      rsp_word_in.occupancy = spq_pkg::to_occupancy(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   assign rem_on_empty  = accept && (req_word.mode == spq_pkg::MODE_REMOVE) && is_empty;
   assign rsp_underflow = (rsp_word_ff.status == spq_pkg::STATUS_UNDERFLOW) && (count_ff == '0);

   `SPQ_ASSERT_IMPLY(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `SPQ_ASSERT_NEXT(a_strobe_follows, clock, reset, accept, rsp_strobe)
   `SPQ_ASSERT_NEXT(a_no_spurious_strobe, clock, reset, !accept, !rsp_strobe)
   `SPQ_ASSERT_NEXT(a_underflow_empty, clock, reset, rem_on_empty, rsp_underflow)
   `SPQ_ASSERT_NEXT(a_insert_grows, clock, reset, ctrl.ins_en, count_ff == $past(count_ff) + CW'(1))

endmodule
